@@ src/sia_pkg.sv @@
// ----------------------------------------------------------------------------
// sia_pkg
// Shared types and constants for the session id allocator.
// ----------------------------------------------------------------------------
package sia_pkg;

    localparam int MAX_ID_DEFAULT = 255;

    // pending map word width and bit index width
    localparam int WORD_W = 16;
    localparam int BIT_W  = 4;

    localparam int VERSION_W = 16;
    localparam logic [VERSION_W-1:0] VERSION_RESET = 16'd1;

    localparam int SID_W    = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    typedef enum logic [0:0] {
        REG_EXPECTED_VERSION = 1'b0
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_HELLO   = 2'd0,
        KIND_READY   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_VERSION    = 3'd1,
        STATUS_EMPTY_NAME = 3'd2,
        STATUS_NO_FREE    = 3'd3,
        STATUS_UNKNOWN    = 3'd4
    } status_t;

endpackage

@@ src/sia_map_mem.sv @@
// ----------------------------------------------------------------------------
// sia_map_mem
// Pending map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sia_map_mem #(
    parameter int WORDS  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic [sia_pkg::WORD_W-1:0] wdata,
    input  logic [ADDR_W-1:0]        raddr,
    output logic [sia_pkg::WORD_W-1:0] rdata
);

    logic [sia_pkg::WORD_W-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ src/session_id_allocator_handshake.sv @@
// ----------------------------------------------------------------------------
// session_id_allocator_handshake
// Round robin session id allocator with a word-wise pending bitmap in RAM.
//
//   channel   signals                                  direction
//   input     in_valid/in_ready, kind, hello_version,
//             first_name_byte, target_id               in
//   output    out_valid/out_ready, status, assigned_id out
//   config    APB: psel penable pwrite paddr pwdata prdata pready
//
// One transaction at a time. Checks that fail, out-of-range ids and unused
// kinds go straight to S_RESP; ready/release pass through S_LOOKUP (one map
// RAM read and write back); hello passes through S_SCAN, one map word scanned
// per cycle starting at the round robin pointer.
// After reset a clearing pass writes MAX_ID/16+1 words (one per cycle) before
// in_ready rises. A stalled output holds the next result in the block.
// ----------------------------------------------------------------------------
module session_id_allocator_handshake #(
    parameter int MAX_ID = sia_pkg::MAX_ID_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    kind,
    input  logic [sia_pkg::VERSION_W-1:0] hello_version,
    input  logic [7:0]                    first_name_byte,
    input  logic [sia_pkg::SID_W-1:0]     target_id,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [sia_pkg::SID_W-1:0]     assigned_id,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sia_pkg::APB_AW-1:0]    paddr,
    input  logic [sia_pkg::APB_DW-1:0]    pwdata,
    output logic [sia_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int WORD_W  = sia_pkg::WORD_W;
    localparam int BIT_W   = sia_pkg::BIT_W;
    localparam int NWORDS  = MAX_ID / WORD_W + 1;
    localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int IDX_W   = WADDR_W + BIT_W;
    localparam int CNT_W   = $clog2(NWORDS + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_RESP
    } state_t;

    state_t                          state_reg, state_next;
    logic [1:0]                      kind_reg, kind_next;
    logic [IDX_W-1:0]                sid_reg, sid_next;
    sia_pkg::status_t                res_status_reg, res_status_next;
    logic [sia_pkg::SID_W-1:0]       res_id_reg, res_id_next;
    logic [IDX_W-1:0]                next_id_reg, next_id_next;
    logic [WADDR_W-1:0]              cur_w_reg, cur_w_next;
    logic [CNT_W-1:0]                scan_cnt_reg, scan_cnt_next;
    logic [WADDR_W-1:0]              clr_cnt_reg, clr_cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic [2:0]                      out_status_reg, out_status_next;
    logic [sia_pkg::SID_W-1:0]       out_id_reg, out_id_next;
    logic [sia_pkg::VERSION_W-1:0]   version_reg;

    logic                            mem_we;
    logic [WADDR_W-1:0]              mem_waddr;
    logic [WORD_W-1:0]               mem_wdata;
    logic [WADDR_W-1:0]              mem_raddr;
    logic [WORD_W-1:0]               mem_rdata;

    logic                            sid_in_range;
    logic [WORD_W-1:0]               id_mask;
    logic [WORD_W-1:0]               ge_mask;
    logic [WORD_W-1:0]               pass_mask;
    logic [WORD_W-1:0]               free_bits;
    logic [BIT_W-1:0]                free_pos;
    logic [IDX_W-1:0]                found_id;
    logic [WADDR_W-1:0]              cur_w_inc;
    logic [BIT_W-1:0]                sid_bit;
    logic                            cfg_wr;

    function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

    sia_map_mem #(
        .WORDS  (NWORDS),
        .ADDR_W (WADDR_W)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[2] == sia_pkg::REG_EXPECTED_VERSION);
    assign prdata = (paddr[2] == sia_pkg::REG_EXPECTED_VERSION)
                    ? {{(sia_pkg::APB_DW - sia_pkg::VERSION_W){1'b0}}, version_reg}
                    : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= sia_pkg::VERSION_RESET;
        end
        else if (cfg_wr)
        begin
            version_reg <= pwdata[sia_pkg::VERSION_W-1:0];
        end
    end

    // scan helpers
    assign sid_in_range = (target_id != '0)
                          && (target_id <= sia_pkg::SID_W'(MAX_ID));
    assign cur_w_inc = (cur_w_reg == WADDR_W'(NWORDS - 1)) ? '0 : cur_w_reg + 1'b1;
    assign ge_mask   = {WORD_W{1'b1}} << next_id_reg[BIT_W-1:0];

    always_comb
    begin
        for (int j = 0; j < WORD_W; j++)
        begin
            id_mask[j] = ({cur_w_reg, BIT_W'(j)} != '0)
                         && ({cur_w_reg, BIT_W'(j)} <= IDX_W'(MAX_ID));
        end
    end

    always_comb
    begin
        if (scan_cnt_reg == '0)
        begin
            pass_mask = ge_mask;
        end
        else if (scan_cnt_reg == CNT_W'(NWORDS))
        begin
            pass_mask = ~ge_mask;
        end
        else
        begin
            pass_mask = {WORD_W{1'b1}};
        end
    end

    assign free_bits = ~mem_rdata & id_mask & pass_mask;
    assign free_pos  = first_set(free_bits);
    assign found_id  = {cur_w_reg, free_pos};
    assign sid_bit   = sid_reg[BIT_W-1:0];

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign assigned_id = out_id_reg;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        sid_next        = sid_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        next_id_next    = next_id_reg;
        cur_w_next      = cur_w_reg;
        scan_cnt_next   = scan_cnt_reg;
        clr_cnt_next    = clr_cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = cur_w_reg;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == WADDR_W'(NWORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next       = kind;
                    sid_next        = target_id[IDX_W-1:0];
                    res_status_next = sia_pkg::STATUS_OK;
                    res_id_next     = '0;
                    state_next      = S_RESP;
                    case (kind)
                        sia_pkg::KIND_HELLO:
                        begin
                            if (hello_version != version_reg)
                            begin
                                res_status_next = sia_pkg::STATUS_VERSION;
                            end
                            else if (first_name_byte == '0)
                            begin
                                res_status_next = sia_pkg::STATUS_EMPTY_NAME;
                            end
                            else
                            begin
                                mem_raddr     = next_id_reg[IDX_W-1:BIT_W];
                                cur_w_next    = next_id_reg[IDX_W-1:BIT_W];
                                scan_cnt_next = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        sia_pkg::KIND_READY, sia_pkg::KIND_RELEASE:
                        begin
                            if (sid_in_range)
                            begin
                                mem_raddr  = target_id[IDX_W-1:BIT_W];
                                state_next = S_LOOKUP;
                            end
                            else if (kind == sia_pkg::KIND_READY)
                            begin
                                res_status_next = sia_pkg::STATUS_UNKNOWN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_LOOKUP:
            begin
                mem_waddr = sid_reg[IDX_W-1:BIT_W];
                mem_wdata = mem_rdata & ~(WORD_W'(1) << sid_bit);
                if (kind_reg == sia_pkg::KIND_RELEASE || mem_rdata[sid_bit])
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    res_status_next = sia_pkg::STATUS_UNKNOWN;
                end
                state_next = S_RESP;
            end

            S_SCAN:
            begin
                if (free_bits != '0)
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = cur_w_reg;
                    mem_wdata    = mem_rdata | (WORD_W'(1) << free_pos);
                    res_id_next  = sia_pkg::SID_W'(found_id);
                    next_id_next = (found_id == IDX_W'(MAX_ID)) ? IDX_W'(1)
                                                               : found_id + 1'b1;
                    state_next   = S_RESP;
                end
                else if (scan_cnt_reg == CNT_W'(NWORDS))
                begin
                    res_status_next = sia_pkg::STATUS_NO_FREE;
                    state_next      = S_RESP;
                end
                else
                begin
                    mem_raddr     = cur_w_inc;
                    cur_w_next    = cur_w_inc;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = res_id_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            next_id_reg   <= IDX_W'(1);
            out_valid_reg <= 1'b0;
            scan_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
            scan_cnt_reg  <= scan_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        sid_reg        <= sid_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        cur_w_reg      <= cur_w_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
    end

endmodule
